### rtl/idq_pkg.sv
// ----------------------------------------------------------------------------
// idq_pkg
// Shared opcodes, status codes and controller/datapath interface types for the
// indexed double-ended store.
// ----------------------------------------------------------------------------
`default_nettype none

package idq_pkg;

  // Operation codes carried by each input transaction.
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;
  localparam logic [2:0] OP_WRITE      = 3'd5;
  localparam logic [2:0] OP_FIND       = 3'd6;

  // Status codes returned with each result.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_INDEX = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // Result source selects.
  localparam logic [1:0] SRC_NOW  = 2'd0;
  localparam logic [1:0] SRC_READ = 2'd1;
  localparam logic [1:0] SRC_SCAN = 2'd2;

  localparam logic [31:0] NEG_ONE = 32'hFFFF_FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       scan_start;
    logic       scan_step;
    logic [1:0] src;
    logic       load_out;
    logic       load_hold;
    logic       hold_to_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;
    logic need_scan;
    logic scan_done;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/idq_ram.sv
// ----------------------------------------------------------------------------
// idq_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module idq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/idq_ctrl.sv
// ----------------------------------------------------------------------------
// idq_ctrl
// Controller state machine: handshakes, sequencing of reads and searches, and
// the result hold stage.
// ----------------------------------------------------------------------------
`default_nettype none

module idq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire idq_pkg::dp_status_t status_i,
  output idq_pkg::ctl_cmd_t        cmd_o
);

  import idq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;
  ctl_cmd_t   cmd;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and command decode.
  always_comb begin
    state_d         = state_q;
    cmd             = '0;
    cmd.accept      = accept;
    cmd.src         = SRC_NOW;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (status_i.need_read) begin
            state_d = S_READ;
          end else if (status_i.need_scan) begin
            cmd.scan_start = 1'b1;
            state_d        = S_SCAN;
          end else if (out_free) begin
            cmd.load_out = 1'b1;
          end else begin
            cmd.load_hold = 1'b1;
            state_d       = S_HOLD;
          end
        end
      end
      S_READ: begin
        cmd.src = SRC_READ;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd.load_hold = 1'b1;
          state_d       = S_HOLD;
        end
      end
      S_SCAN: begin
        cmd.src = SRC_SCAN;
        if (status_i.scan_done) begin
          if (out_free) begin
            cmd.load_out = 1'b1;
            state_d      = S_IDLE;
          end else begin
            cmd.load_hold = 1'b1;
            state_d       = S_HOLD;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.hold_to_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid follows loads into the output register and drains on ready.
  always_comb begin
    if (cmd.load_out || cmd.hold_to_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // A pending result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> out_free)
    else $error("output register loaded while a result is pending");

  // The hold stage is only used while the output register is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD) |-> out_valid_q)
    else $error("hold state entered with an empty output register");

  // Every accepted transaction leaves either busy state or a visible result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ((state_q != S_IDLE) || out_valid_q))
    else $error("accepted transaction produced no result");

endmodule

`default_nettype wire

### rtl/idq_datapath.sv
// ----------------------------------------------------------------------------
// idq_datapath
// Ring-buffer pointers, element memory, search index and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module idq_datapath #(
  parameter int DEPTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire idq_pkg::ctl_cmd_t   cmd_i,
  output idq_pkg::dp_status_t      status_o,
  input  wire logic [2:0]          opcode_i,
  input  wire logic [5:0]          position_i,
  input  wire logic signed [31:0]  data_value_i,
  output logic signed [31:0]       result_value_o,
  output logic [2:0]               result_status_o,
  output logic [6:0]               count_o
);

  import idq_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = AW + 1;
  localparam int PW   = 6;
  localparam int CMPW = (CW > PW) ? CW : PW;

  // Physical slot of a logical offset from a base slot.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [SW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + off;
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return AW'(s);
  endfunction

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q;
  logic [31:0]   key_q;

  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  logic [31:0]   now_value;
  logic [2:0]    now_status;
  logic          need_read;
  logic          need_scan;
  logic          full;
  logic          empty;
  logic          pos_ok;
  logic [AW-1:0] front_dec;
  logic [CW-1:0] idx_nxt;
  logic          scan_hit;
  logic          scan_last;

  logic [31:0]   fin_value;
  logic [2:0]    fin_status;
  logic [CW-1:0] fin_count;

  logic [31:0]   hold_value_q;
  logic [2:0]    hold_status_q;
  logic [CW-1:0] hold_count_q;
  logic [31:0]   out_value_q;
  logic [2:0]    out_status_q;
  logic [CW-1:0] out_count_q;

  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign pos_ok    = (CMPW'(position_i) < CMPW'(count_q));
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;

  // Decode of the offered transaction against the current store state.
  always_comb begin
    now_value  = '0;
    now_status = ST_OK;
    front_d    = front_q;
    count_d    = count_q;
    we         = 1'b0;
    waddr      = front_q;
    need_read  = 1'b0;
    need_scan  = 1'b0;
    case (opcode_i)
      OP_PUSH_FRONT: begin
        if (full) begin
          now_status = ST_FULL;
        end else begin
          front_d = front_dec;
          count_d = count_q + 1'b1;
          waddr   = front_dec;
          we      = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          now_status = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
          waddr   = slot_of(front_q, SW'(count_q));
          we      = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          now_status = ST_EMPTY;
        end else begin
          front_d = slot_of(front_q, SW'(1));
          count_d = count_q - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          now_status = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      OP_READ: begin
        if (!pos_ok) begin
          now_value  = NEG_ONE;
          now_status = ST_BAD_INDEX;
        end else begin
          need_read = 1'b1;
        end
      end
      OP_WRITE: begin
        if (!pos_ok) begin
          now_status = ST_BAD_INDEX;
        end else begin
          waddr = slot_of(front_q, SW'(position_i));
          we    = 1'b1;
        end
      end
      OP_FIND: begin
        if (empty) begin
          now_value  = NEG_ONE;
          now_status = ST_NOT_FOUND;
        end else begin
          need_scan = 1'b1;
        end
      end
      default: begin
        now_value = '0;
      end
    endcase
  end

  // Search compare: the registered read data belongs to entry idx_q.
  assign idx_nxt   = CW'(idx_q) + CW'(1);
  assign scan_hit  = (rdata == key_q);
  assign scan_last = (idx_nxt == count_q);

  // Read address: next entry while scanning, the offered read, else front slot.
  always_comb begin
    if (cmd_i.scan_step) begin
      raddr = slot_of(front_q, SW'(idx_nxt));
    end else if (opcode_i == OP_READ) begin
      raddr = slot_of(front_q, SW'(position_i));
    end else begin
      raddr = front_q;
    end
  end

  idq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we && cmd_i.accept),
    .waddr_i (waddr),
    .wdata_i (data_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Store pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.accept) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // Search index and key.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      idx_q <= '0;
      key_q <= data_value_i;
    end else if (cmd_i.scan_step) begin
      idx_q <= AW'(idx_nxt);
    end
  end

  // Result selection.
  always_comb begin
    case (cmd_i.src)
      SRC_READ: begin
        fin_value  = rdata;
        fin_status = ST_OK;
        fin_count  = count_q;
      end
      SRC_SCAN: begin
        fin_value  = scan_hit ? 32'(idx_q) : NEG_ONE;
        fin_status = scan_hit ? ST_OK : ST_NOT_FOUND;
        fin_count  = count_q;
      end
      default: begin
        fin_value  = now_value;
        fin_status = now_status;
        fin_count  = count_d;
      end
    endcase
  end

  // Hold stage and output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_hold) begin
      hold_value_q  <= fin_value;
      hold_status_q <= fin_status;
      hold_count_q  <= fin_count;
    end
    if (cmd_i.load_out) begin
      out_value_q  <= fin_value;
      out_status_q <= fin_status;
      out_count_q  <= fin_count;
    end else if (cmd_i.hold_to_out) begin
      out_value_q  <= hold_value_q;
      out_status_q <= hold_status_q;
      out_count_q  <= hold_count_q;
    end
  end

  assign status_o.need_read = need_read;
  assign status_o.need_scan = need_scan;
  assign status_o.scan_done = scan_hit || scan_last;

  assign result_value_o  = out_value_q;
  assign result_status_o = out_status_q;
  assign count_o         = 7'(out_count_q);

  // The element count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count beyond capacity");

  // The front pointer always names a real slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    SW'(front_q) < SW'(DEPTH))
    else $error("front pointer out of range");

endmodule

`default_nettype wire

### rtl/indexed_deque_store_top.sv
// ----------------------------------------------------------------------------
// indexed_deque_store_top
// Bounded double-ended store of signed 32-bit elements in a ring buffer, with
// push/pop at both ends, indexed read and write, and linear search.
//
//   Channel  Direction  Handshake               Fields
//   in       input      in_valid_i/in_ready_o   opcode_i, position_i, data_value_i
//   out      output     out_valid_o/out_ready_i result_value_o, status_o, count_o
//
// Push, pop, write, a read at a bad index and a find on an empty store are
// answered from the decode. A good read waits on the registered RAM read.
// A find compares the entries one per cycle, stopping at a match or the last
// entry, through the single RAM read port; input is held off meanwhile.
// Reset clears pointers, count and control state, not the element memory.
// A stalled result waits in a hold stage, so the output register never drops one.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_deque_store_top #(
  parameter int DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         opcode_i,
  input  wire logic [5:0]         position_i,
  input  wire logic signed [31:0] data_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      result_value_o,
  output logic [2:0]              status_o,
  output logic [6:0]              count_o
);

  import idq_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t dp_status;

  // Sequencing and handshakes.
  idq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  // Store, pointers and result registers.
  idq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .opcode_i        (opcode_i),
    .position_i      (position_i),
    .data_value_i    (data_value_i),
    .result_value_o  (result_value_o),
    .result_status_o (status_o),
    .count_o         (count_o)
  );

endmodule

`default_nettype wire
